// ===== hw/rtl/attitude_gyro_accel_fusion_filter_macros.svh =====
// assertion macros used by the checker file agaff_chk.sv
`ifndef ATTITUDE_GYRO_ACCEL_FUSION_FILTER_MACROS_SVH
`define ATTITUDE_GYRO_ACCEL_FUSION_FILTER_MACROS_SVH

// same-cycle implication, the consequent may carry its own delay
`define AGAFF_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AGAFF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/agaff_pkg.sv =====
package agaff_pkg;

    localparam int INPUT_SCALE_SHIFT = 6;
    localparam int RATE_GAIN_SHIFT   = 14;
    localparam int ANGLE_GAIN_SHIFT  = 8;
    localparam int BIAS_GAIN_SHIFT   = 14;

    localparam int GAIN_W = 16;
    localparam int ADDR_W = 4;

    // register indexes on paddr[3:2]
    localparam logic [1:0] REG_RATE_GAIN  = 2'd0;
    localparam logic [1:0] REG_ANGLE_GAIN = 2'd1;
    localparam logic [1:0] REG_BIAS_GAIN  = 2'd2;

    localparam logic [GAIN_W-1:0] RATE_GAIN_RST  = 16'd128;
    localparam logic [GAIN_W-1:0] ANGLE_GAIN_RST = 16'd4;
    localparam logic [GAIN_W-1:0] BIAS_GAIN_RST  = 16'd1;

    // multiplier gain operand
    localparam logic [1:0] GSEL_RATE  = 2'd0;
    localparam logic [1:0] GSEL_ANGLE = 2'd1;
    localparam logic [1:0] GSEL_BIAS  = 2'd2;

    // state update selected for one axis
    localparam logic [1:0] UPD_NONE  = 2'd0;
    localparam logic [1:0] UPD_ERR   = 2'd1;
    localparam logic [1:0] UPD_ANGLE = 2'd2;
    localparam logic [1:0] UPD_BIAS  = 2'd3;

    typedef struct packed {
        logic               action;
        logic signed [15:0] pitch_rate_sample;
        logic signed [15:0] pitch_angle_sample;
        logic signed [15:0] roll_rate_sample;
        logic signed [15:0] roll_angle_sample;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] pitch_angle_est;
        logic signed [31:0] pitch_rate_est;
        logic signed [31:0] pitch_bias_est;
        logic signed [31:0] roll_angle_est;
        logic signed [31:0] roll_rate_est;
        logic signed [31:0] roll_bias_est;
    } t_out_word;

    typedef struct packed {
        logic       ld_in;
        logic       clear;
        logic       mul_en;
        logic       mul_err;
        logic       mul_axis;
        logic [1:0] mul_gain;
        logic [1:0] upd;
        logic       upd_axis;
        logic       ld_out;
    } t_dp_cmd;

endpackage

// ===== hw/rtl/agaff_ctrl.sv =====
module agaff_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_action,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output agaff_pkg::t_dp_cmd o_cmd
);
    import agaff_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MR0   = 4'd1;
    localparam logic [3:0] ST_ERR0  = 4'd2;
    localparam logic [3:0] ST_ERR1  = 4'd3;
    localparam logic [3:0] ST_ANG0  = 4'd4;
    localparam logic [3:0] ST_ANG1  = 4'd5;
    localparam logic [3:0] ST_BIAS0 = 4'd6;
    localparam logic [3:0] ST_BIAS1 = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_accept;
    logic       w_out_free;
    t_dp_cmd    w_cmd;

    assign w_accept   = (r_state == ST_IDLE) && i_in_valid;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    w_cmd.ld_in = !i_action;
                    w_cmd.clear = i_action;
                    n_state     = i_action ? ST_DONE : ST_MR0;
                end
            end
            ST_MR0: begin
                w_cmd.mul_en   = 1'b1;
                w_cmd.mul_gain = GSEL_RATE;
                n_state        = ST_ERR0;
            end
            ST_ERR0: begin
                w_cmd.upd      = UPD_ERR;
                w_cmd.mul_en   = 1'b1;
                w_cmd.mul_axis = 1'b1;
                w_cmd.mul_gain = GSEL_RATE;
                n_state        = ST_ERR1;
            end
            ST_ERR1: begin
                w_cmd.upd      = UPD_ERR;
                w_cmd.upd_axis = 1'b1;
                w_cmd.mul_en   = 1'b1;
                w_cmd.mul_err  = 1'b1;
                w_cmd.mul_gain = GSEL_ANGLE;
                n_state        = ST_ANG0;
            end
            ST_ANG0: begin
                w_cmd.upd      = UPD_ANGLE;
                w_cmd.mul_en   = 1'b1;
                w_cmd.mul_err  = 1'b1;
                w_cmd.mul_axis = 1'b1;
                w_cmd.mul_gain = GSEL_ANGLE;
                n_state        = ST_ANG1;
            end
            ST_ANG1: begin
                w_cmd.upd      = UPD_ANGLE;
                w_cmd.upd_axis = 1'b1;
                w_cmd.mul_en   = 1'b1;
                w_cmd.mul_err  = 1'b1;
                w_cmd.mul_gain = GSEL_BIAS;
                n_state        = ST_BIAS0;
            end
            ST_BIAS0: begin
                w_cmd.upd      = UPD_BIAS;
                w_cmd.mul_en   = 1'b1;
                w_cmd.mul_err  = 1'b1;
                w_cmd.mul_axis = 1'b1;
                w_cmd.mul_gain = GSEL_BIAS;
                n_state        = ST_BIAS1;
            end
            ST_BIAS1: begin
                w_cmd.upd      = UPD_BIAS;
                w_cmd.upd_axis = 1'b1;
                n_state        = ST_DONE;
            end
            ST_DONE: begin
                // wait for the output register to free up
                if (w_out_free) begin
                    w_cmd.ld_out = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_cmd.ld_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

// ===== hw/rtl/agaff_dp.sv =====
module agaff_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  agaff_pkg::t_in_word i_in_word,
    input  agaff_pkg::t_dp_cmd  i_cmd,
    input  logic [15:0]         i_rate_gain,
    input  logic [15:0]         i_angle_gain,
    input  logic [15:0]         i_bias_gain,
    output agaff_pkg::t_out_word o_out_word
);
    import agaff_pkg::*;

    function automatic logic signed [31:0] scale_sample(input logic signed [15:0] s);
        logic signed [31:0] ext;
        ext = {{16{s[15]}}, s};
        return ext <<< INPUT_SCALE_SHIFT;
    endfunction

    logic signed [31:0] r_angle [2];
    logic signed [31:0] r_bias  [2];
    logic signed [31:0] r_rate  [2];
    logic signed [31:0] r_err   [2];
    logic signed [31:0] r_acc   [2];
    logic        [31:0] r_prod;
    t_out_word          r_out;

    logic        [31:0] w_mul_a;
    logic        [15:0] w_mul_b;
    logic        [31:0] w_prod;
    logic signed [31:0] w_rate_inc;
    logic signed [31:0] w_angle_pull;
    logic signed [31:0] w_bias_inc;
    logic signed [31:0] w_ang;

    // one shared 32x16 multiplier, low word kept (wraps like 32-bit int)
    always_comb begin
        w_mul_a = i_cmd.mul_err ? r_err[i_cmd.mul_axis] : r_rate[i_cmd.mul_axis];
        case (i_cmd.mul_gain)
            GSEL_RATE:  w_mul_b = i_rate_gain;
            GSEL_ANGLE: w_mul_b = i_angle_gain;
            GSEL_BIAS:  w_mul_b = i_bias_gain;
            default:    w_mul_b = '0;
        endcase
        w_prod = w_mul_a * {16'd0, w_mul_b};
    end

    assign w_rate_inc   = $signed(r_prod) >>> RATE_GAIN_SHIFT;
    assign w_angle_pull = $signed(r_prod) >>> ANGLE_GAIN_SHIFT;
    assign w_bias_inc   = $signed(r_prod) >>> BIAS_GAIN_SHIFT;
    assign w_ang        = r_angle[i_cmd.upd_axis] + w_rate_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle[0] <= '0;
            r_angle[1] <= '0;
            r_bias[0]  <= '0;
            r_bias[1]  <= '0;
        end else if (i_cmd.clear) begin
            r_angle[0] <= '0;
            r_angle[1] <= '0;
            r_bias[0]  <= '0;
            r_bias[1]  <= '0;
        end else begin
            case (i_cmd.upd)
                UPD_ERR:   r_angle[i_cmd.upd_axis] <= w_ang;
                UPD_ANGLE: r_angle[i_cmd.upd_axis] <= r_angle[i_cmd.upd_axis] - w_angle_pull;
                UPD_BIAS:  r_bias[i_cmd.upd_axis]  <= r_bias[i_cmd.upd_axis] + w_bias_inc;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_rate[0] <= '0;
            r_rate[1] <= '0;
        end else if (i_cmd.ld_in) begin
            r_rate[0] <= scale_sample(i_in_word.pitch_rate_sample) - r_bias[0];
            r_rate[1] <= scale_sample(i_in_word.roll_rate_sample) - r_bias[1];
            r_acc[0]  <= scale_sample(i_in_word.pitch_angle_sample);
            r_acc[1]  <= scale_sample(i_in_word.roll_angle_sample);
        end
        if (i_cmd.upd == UPD_ERR) begin
            r_err[i_cmd.upd_axis] <= w_ang - r_acc[i_cmd.upd_axis];
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_cmd.ld_out) begin
            r_out.pitch_angle_est <= r_angle[0];
            r_out.pitch_rate_est  <= r_rate[0];
            r_out.pitch_bias_est  <= r_bias[0];
            r_out.roll_angle_est  <= r_angle[1];
            r_out.roll_rate_est   <= r_rate[1];
            r_out.roll_bias_est   <= r_bias[1];
        end
    end

    assign o_out_word = r_out;

endmodule

// ===== hw/rtl/attitude_gyro_accel_fusion_filter.sv =====
// channel   direction  handshake               word
// in        input      i_in_valid / o_in_stall  t_in_word (action, four 16-bit samples)
// out       output     o_out_valid / i_out_stall t_out_word (six 32-bit estimates)
// config    input      apb psel/penable         three 16-bit gains at 0x0, 0x4, 0x8
//
// a filter word steps through the multiply and update states and returns to idle once the
// output is free; six products go through one shared 32x16 multiplier, one per cycle
// a clear word zeroes angles, rates and biases and goes from idle straight to the done state
// the result waits in an output register, a stalled output holds the block in its last step
// synchronous active-low reset clears angles, biases and restores the gain defaults
module attitude_gyro_accel_fusion_filter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  agaff_pkg::t_in_word   i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output agaff_pkg::t_out_word  o_out_word,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import agaff_pkg::*;

    logic [GAIN_W-1:0] r_rate_gain;
    logic [GAIN_W-1:0] r_angle_gain;
    logic [GAIN_W-1:0] r_bias_gain;
    logic              w_cfg_wr;
    logic [1:0]        w_reg_idx;
    t_dp_cmd           w_cmd;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_gain  <= RATE_GAIN_RST;
            r_angle_gain <= ANGLE_GAIN_RST;
            r_bias_gain  <= BIAS_GAIN_RST;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_RATE_GAIN:  r_rate_gain  <= pwdata[GAIN_W-1:0];
                REG_ANGLE_GAIN: r_angle_gain <= pwdata[GAIN_W-1:0];
                REG_BIAS_GAIN:  r_bias_gain  <= pwdata[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_RATE_GAIN:  prdata = {16'd0, r_rate_gain};
            REG_ANGLE_GAIN: prdata = {16'd0, r_angle_gain};
            REG_BIAS_GAIN:  prdata = {16'd0, r_bias_gain};
            default:        prdata = '0;
        endcase
    end

    agaff_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_in_word.action),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    agaff_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_word    (i_in_word),
        .i_cmd        (w_cmd),
        .i_rate_gain  (r_rate_gain),
        .i_angle_gain (r_angle_gain),
        .i_bias_gain  (r_bias_gain),
        .o_out_word   (o_out_word)
    );

endmodule

// ===== hw/rtl/agaff_chk.sv =====
`include "attitude_gyro_accel_fusion_filter_macros.svh"

module agaff_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input agaff_pkg::t_in_word  i_in_word,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input agaff_pkg::t_out_word o_out_word
);
    import agaff_pkg::*;

    logic w_in_acc;
    assign w_in_acc = i_in_valid && !o_in_stall;

    // a stalled result word holds
    `AGAFF_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word), "stalled output word changed")

    // busy right after taking a word
    `AGAFF_ASSERT_NEXT(a_busy_after_accept, w_in_acc, o_in_stall, "input taken while busy")

    // a filter word still holds the block busy when it reaches its done state
    `AGAFF_ASSERT(a_filter_busy, w_in_acc && !i_in_word.action, ##8 o_in_stall, "filter word finished too early")

    // a clear word with a free output passes the done state and reports an all-zero result
    `AGAFF_ASSERT(a_clear_result, w_in_acc && i_in_word.action && !o_out_valid, ##2 (o_out_valid && (o_out_word == '0)), "clear did not report zeros")

endmodule

bind attitude_gyro_accel_fusion_filter agaff_chk u_agaff_chk (.*);

// ===== tb/sv/attitude_fusion_checker.sv =====
`timescale 1ns / 100ps

module attitude_fusion_checker
    import agaff_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_word    i_in_word,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_word   i_out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          o_mismatch_count,
    output int          o_pending_estimates
);

    typedef struct packed {
        logic [31:0] angle;
        logic [31:0] rate;
        logic [31:0] bias;
    } t_axis_est;

    localparam int N_FIELDS = 6;

    string field_name [N_FIELDS] = '{"pitch_angle_est", "pitch_rate_est", "pitch_bias_est",
                                     "roll_angle_est", "roll_rate_est", "roll_bias_est"};

    logic [GAIN_W-1:0] rate_gain;
    logic [GAIN_W-1:0] angle_gain;
    logic [GAIN_W-1:0] bias_gain;
    logic [31:0]       pitch_angle;
    logic [31:0]       pitch_bias;
    logic [31:0]       roll_angle;
    logic [31:0]       roll_bias;
    t_out_word         estimate_q [$];

    initial begin
        o_mismatch_count    = 0;
        o_pending_estimates = 0;
    end

    // one axis of the filter, all sums and products wrap at 32 bits
    function automatic t_axis_est advance_axis(input logic [31:0] angle,
                                               input logic [31:0] bias,
                                               input logic [15:0] rate_smp,
                                               input logic [15:0] angle_smp);
        logic [31:0]        ang;
        logic [31:0]        err;
        logic [31:0]        prod;
        logic signed [31:0] step;
        t_axis_est          est;
        est.rate = ({{16{rate_smp[15]}}, rate_smp} << INPUT_SCALE_SHIFT) - bias;
        prod     = est.rate * {16'b0, rate_gain};
        step     = $signed(prod) >>> RATE_GAIN_SHIFT;
        ang      = angle + step;
        err      = ang - ({{16{angle_smp[15]}}, angle_smp} << INPUT_SCALE_SHIFT);
        prod     = err * {16'b0, angle_gain};
        step     = $signed(prod) >>> ANGLE_GAIN_SHIFT;
        est.angle = ang - step;
        prod     = err * {16'b0, bias_gain};
        step     = $signed(prod) >>> BIAS_GAIN_SHIFT;
        est.bias = bias + step;
        return est;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (o_mismatch_count < 10) begin
            $display("mismatch %s: expected %h actual %h", what, want, got);
        end
        o_mismatch_count = o_mismatch_count + 1;
    endtask

    always @(posedge i_clk) begin
        t_out_word         got;
        t_out_word         want;
        t_axis_est         p_est;
        t_axis_est         r_est;
        logic [GAIN_W-1:0] read_want;
        bit                readable;
        if (!i_rst_n) begin
            rate_gain   = RATE_GAIN_RST;
            angle_gain  = ANGLE_GAIN_RST;
            bias_gain   = BIAS_GAIN_RST;
            pitch_angle = '0;
            pitch_bias  = '0;
            roll_angle  = '0;
            roll_bias   = '0;
            estimate_q.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[3:2])
                        REG_RATE_GAIN:  rate_gain  = pwdata[GAIN_W-1:0];
                        REG_ANGLE_GAIN: angle_gain = pwdata[GAIN_W-1:0];
                        REG_BIAS_GAIN:  bias_gain  = pwdata[GAIN_W-1:0];
                        default: ;
                    endcase
                end else begin
                    readable  = 1'b1;
                    read_want = '0;
                    case (paddr[3:2])
                        REG_RATE_GAIN:  read_want = rate_gain;
                        REG_ANGLE_GAIN: read_want = angle_gain;
                        REG_BIAS_GAIN:  read_want = bias_gain;
                        default:        readable  = 1'b0;
                    endcase
                    if (readable && prdata[GAIN_W-1:0] !== read_want) begin
                        note_mismatch("register read", 32'(read_want), prdata);
                    end
                end
            end

            // results first: a word leaving now belongs to an earlier input
            if (i_out_valid && !i_out_stall) begin
                got = i_out_word;
                if (estimate_q.size() == 0) begin
                    note_mismatch("unexpected word", 'x, got[191 -: 32]);
                end else begin
                    want = estimate_q.pop_front();
                    for (int k = 0; k < N_FIELDS; k++) begin
                        if (got[191-32*k -: 32] !== want[191-32*k -: 32]) begin
                            note_mismatch(field_name[k], want[191-32*k -: 32],
                                          got[191-32*k -: 32]);
                        end
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                if (i_in_word.action) begin
                    pitch_angle = '0;
                    pitch_bias  = '0;
                    roll_angle  = '0;
                    roll_bias   = '0;
                    want        = '0;
                end else begin
                    p_est = advance_axis(pitch_angle, pitch_bias,
                                         i_in_word.pitch_rate_sample,
                                         i_in_word.pitch_angle_sample);
                    r_est = advance_axis(roll_angle, roll_bias,
                                         i_in_word.roll_rate_sample,
                                         i_in_word.roll_angle_sample);
                    pitch_angle = p_est.angle;
                    pitch_bias  = p_est.bias;
                    roll_angle  = r_est.angle;
                    roll_bias   = r_est.bias;
                    want.pitch_angle_est = p_est.angle;
                    want.pitch_rate_est  = p_est.rate;
                    want.pitch_bias_est  = p_est.bias;
                    want.roll_angle_est  = r_est.angle;
                    want.roll_rate_est   = r_est.rate;
                    want.roll_bias_est   = r_est.bias;
                end
                estimate_q.push_back(want);
            end
        end
        o_pending_estimates = estimate_q.size();
    end

endmodule

// ===== tb/sv/tb_attitude_gyro_accel_fusion_filter.sv =====
`timescale 1ns / 100ps

module tb_attitude_gyro_accel_fusion_filter;
    import agaff_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_ITEMS  = 180;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 24;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_word    i_in_word;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_word   o_out_word;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatch_count;
    int pending_estimates;
    int cycle_count = 0;
    bit idle_on = 1'b1;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int stall_left = 0;

    always #4 i_clk = ~i_clk;

    attitude_gyro_accel_fusion_filter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    attitude_fusion_checker checker_i (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_stall          (o_in_stall),
        .i_in_word           (i_in_word),
        .i_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .i_out_word          (o_out_word),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .o_mismatch_count    (mismatch_count),
        .o_pending_estimates (pending_estimates)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver: random stall bursts, plus a long hold-off when asked for
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
            end else if (holds_served < hold_requests) begin
                holds_served++;
                hold_left = LONG_HOLD;
            end else if (stall_left > 0) begin
                stall_left--;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 9);
            end
            i_out_stall <= (hold_left > 0) || (stall_left > 0);
        end
    end

    function automatic t_in_word make_word(input logic action, input logic [15:0] pr,
                                           input logic [15:0] pa, input logic [15:0] rr,
                                           input logic [15:0] ra);
        t_in_word w;
        w.action             = action;
        w.pitch_rate_sample  = pr;
        w.pitch_angle_sample = pa;
        w.roll_rate_sample   = rr;
        w.roll_angle_sample  = ra;
        return w;
    endfunction

    function automatic logic [15:0] rand_sample();
        logic [15:0] s;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: s = 16'($urandom());
            4, 5, 6, 7: s = 16'($urandom_range(0, 4095) - 2048);
            8: begin
                case ($urandom_range(0, 3))
                    0:       s = 16'h7FFF;
                    1:       s = 16'h8000;
                    2:       s = 16'h0000;
                    default: s = 16'hFFFF;
                endcase
            end
            default: s = 16'($urandom_range(0, 15) - 8);
        endcase
        return s;
    endfunction

    function automatic t_in_word random_word();
        return make_word($urandom_range(0, 24) == 0, rand_sample(), rand_sample(),
                         rand_sample(), rand_sample());
    endfunction

    task automatic send_word(input t_in_word w);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic apb_access(input bit write, input logic [3:0] addr,
                              input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // the last word must not be offered again while the block drains
    task automatic wait_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_estimates != 0) @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [15:0] rg, input logic [15:0] ag,
                             input logic [15:0] bg, input bit idle, input bit long_hold);
        wait_drain();
        i_in_valid <= 1'b0;
        // upper data bits are noise, the gains are 16 bits
        apb_access(1'b1, {REG_RATE_GAIN, 2'b00}, {16'($urandom()), rg});
        apb_access(1'b1, {REG_ANGLE_GAIN, 2'b00}, {16'($urandom()), ag});
        apb_access(1'b1, {REG_BIAS_GAIN, 2'b00}, {16'($urandom()), bg});
        apb_access(1'b0, {REG_RATE_GAIN, 2'b00}, '0);
        apb_access(1'b0, {REG_ANGLE_GAIN, 2'b00}, '0);
        apb_access(1'b0, {REG_BIAS_GAIN, 2'b00}, '0);
        idle_on = idle;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (long_hold && i == PHASE_ITEMS / 3) begin
                hold_requests++;
            end
            send_word(random_word());
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_word  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed words under the reset gains
        send_word(make_word(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        send_word(make_word(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_word(make_word(1'b0, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_word(make_word(1'b0, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF));
        // clear ignores the samples it carries
        send_word(make_word(1'b1, 16'h1234, 16'hBEEF, 16'h7FFF, 16'h8000));
        send_word(make_word(1'b0, 16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF));
        // steady tilt lets the bias start to move
        repeat (6) send_word(make_word(1'b0, 16'd100, 16'd2000, -16'sd100, -16'sd2000));
        send_word(make_word(1'b1, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
        send_word(make_word(1'b0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000));
        repeat (2) begin
            send_word(make_word(1'b0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
            send_word(make_word(1'b0, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
        end

        // address past the last register must leave the gains alone
        wait_drain();
        i_in_valid <= 1'b0;
        apb_access(1'b1, 4'hC, $urandom());

        run_phase(16'd128, 16'd4, 16'd1, 1'b1, 1'b0);
        run_phase(16'd0, 16'd0, 16'd0, 1'b1, 1'b0);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        run_phase(16'd16384, 16'd256, 16'd16384, 1'b0, 1'b0);
        run_phase(16'($urandom()), 16'($urandom()), 16'($urandom()), 1'b1, 1'b0);
        run_phase(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 255)),
                  16'($urandom_range(0, 255)), 1'b1, 1'b0);
        run_phase(16'd1, 16'hFFFF, 16'd0, 1'b1, 1'b0);
        run_phase(16'($urandom()), 16'($urandom()), 16'($urandom()), 1'b0, 1'b0);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_estimates != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && pending_estimates == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/agaff_pkg.sv
hw/rtl/agaff_ctrl.sv
hw/rtl/agaff_dp.sv
hw/rtl/attitude_gyro_accel_fusion_filter.sv
hw/rtl/agaff_chk.sv
tb/sv/attitude_fusion_checker.sv
tb/sv/tb_attitude_gyro_accel_fusion_filter.sv
